/* rtl/aps_pkg.sv */
// Shared types, constants and helper functions for the antisymmetric packed scatter.
package aps_pkg;

  // Stream and configuration widths
  localparam int IN_W        = 120;
  localparam int OUT_W       = 120;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LAYOUT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_SELECT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OCC_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VIR_COUNT = 3'd4;

  // Layout codes
  localparam logic [1:0] LAYOUT_VIR  = 2'd0;
  localparam logic [1:0] LAYOUT_OCC  = 2'd1;
  localparam logic [1:0] LAYOUT_FULL = 2'd2;

  // Reset values of the registers
  localparam logic [1:0]         RST_LAYOUT    = LAYOUT_VIR;
  localparam logic               RST_OP_SELECT = 1'b0;
  localparam logic signed [31:0] RST_SCALE     = 32'sd16777216;
  localparam logic [4:0]         RST_OCC_COUNT = 5'd16;
  localparam logic [5:0]         RST_VIR_COUNT = 6'd32;

  // Permutation table: entry p holds the sorted ranks {r2,r1,r0} of the element triple
  localparam int PERM_COUNT = 6;
  localparam logic [PERM_COUNT-1:0][5:0] PERM_TAB = {
    6'b00_01_10,   // (2,1,0)
    6'b01_10_00,   // (0,2,1)
    6'b10_00_01,   // (1,0,2)
    6'b01_00_10,   // (2,0,1)
    6'b00_10_01,   // (1,2,0)
    6'b10_01_00    // identity
  };
  localparam logic [PERM_COUNT-1:0] PERM_ODD   = 6'b111000;

  // Operator membership masks over the permutation numbers
  localparam logic [PERM_COUNT-1:0] SET_ALL    = 6'h3F;
  localparam logic [PERM_COUNT-1:0] SET_FIRST  = 6'h29;
  localparam logic [PERM_COUNT-1:0] SET_SECOND = 6'h31;

  // Binomial tables over a 6-bit argument, 16-bit modular entries
  localparam int TAB_DEPTH = 64;
  typedef logic [TAB_DEPTH-1:0][15:0] binom_tab_t;

  function automatic binom_tab_t build_choose3();
    binom_tab_t t;
    int m;
    for (m = 0; m < TAB_DEPTH; m++) begin
      t[m] = (m < 3) ? 16'd0 : 16'(m * (m - 1) * (m - 2) / 6);
    end
    return t;
  endfunction

  function automatic binom_tab_t build_choose2();
    binom_tab_t t;
    int m;
    for (m = 0; m < TAB_DEPTH; m++) begin
      t[m] = (m < 2) ? 16'd0 : 16'(m * (m - 1) / 2);
    end
    return t;
  endfunction

  localparam binom_tab_t CHOOSE3 = build_choose3();
  localparam binom_tab_t CHOOSE2 = build_choose2();

  // Sorted triple with its permutation number
  typedef struct packed {
    logic       distinct;
    logic [2:0] perm;
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
  } triple_t;

  // Rank each index among the three, sort by rank, look up the permutation
  function automatic triple_t classify(input logic [5:0] x0, input logic [5:0] x1,
                                       input logic [5:0] x2);
    triple_t    t;
    logic [1:0] r0;
    logic [1:0] r1;
    logic [1:0] r2;
    int         p;
    t.distinct = (x0 != x1) && (x0 != x2) && (x1 != x2);
    r0 = {1'b0, x1 < x0} + {1'b0, x2 < x0};
    r1 = {1'b0, x0 < x1} + {1'b0, x2 < x1};
    r2 = {1'b0, x0 < x2} + {1'b0, x1 < x2};
    t.s0 = ((r0 == 2'd0) ? x0 : 6'd0) | ((r1 == 2'd0) ? x1 : 6'd0) |
           ((r2 == 2'd0) ? x2 : 6'd0);
    t.s1 = ((r0 == 2'd1) ? x0 : 6'd0) | ((r1 == 2'd1) ? x1 : 6'd0) |
           ((r2 == 2'd1) ? x2 : 6'd0);
    t.s2 = ((r0 == 2'd2) ? x0 : 6'd0) | ((r1 == 2'd2) ? x1 : 6'd0) |
           ((r2 == 2'd2) ? x2 : 6'd0);
    t.perm = 3'd0;
    for (p = 0; p < PERM_COUNT; p++) begin
      if (PERM_TAB[p] == {r2, r1, r0}) begin
        t.perm = 3'(p);
      end
    end
    return t;
  endfunction

  // Clamp a signed 64-bit product into the 48-bit result field
  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic [47:0] r;
    if ((&v[63:47]) || !(|v[63:47])) begin
      r = v[47:0];
    end else if (v[63]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/antisymmetric_packed_scatter.sv */
// Top level: three-stage pipeline; sorts, ranks, scales one tensor element per unstalled cycle.
//
// Takes one complex element with its occupied and virtual index triples per transaction and
// gives at most one scaled, signed contribution for its packed antisymmetric slot; elements
// with repeated indices, out-of-range indices, a permutation outside the selected operator
// or an unused layout code are dropped silently. One element can be accepted every cycle
// while the output is not stalled, and a result is registered in stages one, two and three.
// Stage one sorts the triples and runs all checks, stage two reads the binomial tables and
// runs the two 32x32 multiplies, stage three sums the ranks, applies the sign and clamps to
// 48 bits. Each stage stalls only while it is full and the one after it cannot take its
// item, so bubbles from dropped elements are squeezed out. Configuration writes are taken
// at any time but must only be issued while no element is in flight.
module antisymmetric_packed_scatter #(
  parameter int MAX_OCC = 16,
  parameter int MAX_VIR = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input element
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // occ_i, occ_j, occ_k, vir_a, vir_b, vir_c, packed_occ_in, packed_vir_in, elem_re, elem_im
  input  logic [aps_pkg::IN_W-1:0]          s_tdata,
  // Result
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // packed_row, packed_col, contrib_re, contrib_im
  output logic [aps_pkg::OUT_W-1:0]         m_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [1:0]         layout;
  logic               op_select;
  logic signed [31:0] scale;
  logic [4:0]         occ_count;
  logic [5:0]         vir_count;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout    <= aps_pkg::RST_LAYOUT;
      op_select <= aps_pkg::RST_OP_SELECT;
      scale     <= aps_pkg::RST_SCALE;
      occ_count <= aps_pkg::RST_OCC_COUNT;
      vir_count <= aps_pkg::RST_VIR_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aps_pkg::REG_LAYOUT:    layout    <= cfg_data[1:0];
        aps_pkg::REG_OP_SELECT: op_select <= cfg_data[0];
        aps_pkg::REG_SCALE:     scale     <= $signed(cfg_data[31:0]);
        aps_pkg::REG_OCC_COUNT: occ_count <= cfg_data[4:0];
        aps_pkg::REG_VIR_COUNT: vir_count <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Counts clamped to the configured maxima
  logic [5:0] n_occ;
  logic [5:0] n_vir;
  assign n_occ = (int'(occ_count) > MAX_OCC) ? 6'(MAX_OCC) : {1'b0, occ_count};
  assign n_vir = (int'(vir_count) > MAX_VIR) ? 6'(MAX_VIR) : vir_count;

  // Stage handshake: a stage loads when it is empty or its contents move on
  logic v1, v2, v3;
  logic en1, en2, en3;
  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !rst;

  // Input field unpacking
  logic [3:0]         occ_i, occ_j, occ_k;
  logic [4:0]         vir_a, vir_b, vir_c;
  logic [9:0]         packed_occ_in;
  logic [12:0]        packed_vir_in;
  logic signed [31:0] elem_re, elem_im;
  assign occ_i         = s_tdata[3:0];
  assign occ_j         = s_tdata[7:4];
  assign occ_k         = s_tdata[11:8];
  assign vir_a         = s_tdata[16:12];
  assign vir_b         = s_tdata[21:17];
  assign vir_c         = s_tdata[26:22];
  assign packed_occ_in = s_tdata[36:27];
  assign packed_vir_in = s_tdata[49:37];
  assign elem_re       = $signed(s_tdata[81:50]);
  assign elem_im       = $signed(s_tdata[113:82]);

  // Stage one: sort and classify both triples and check those that the layout uses
  aps_pkg::triple_t tri_occ, tri_vir;
  logic [5:0]       op_set;
  logic             ok_occ, ok_vir, pin_occ_ok, pin_vir_ok, hit, neg;

  assign tri_occ = aps_pkg::classify({2'b00, occ_i}, {2'b00, occ_j}, {2'b00, occ_k});
  assign tri_vir = aps_pkg::classify({1'b0, vir_a}, {1'b0, vir_b}, {1'b0, vir_c});

  always_comb begin
    if (layout == aps_pkg::LAYOUT_FULL) begin
      op_set = op_select ? aps_pkg::SET_FIRST : aps_pkg::SET_ALL;
    end else begin
      op_set = op_select ? aps_pkg::SET_SECOND : aps_pkg::SET_FIRST;
    end
  end

  assign ok_occ = tri_occ.distinct && (tri_occ.s2 < n_occ) && op_set[tri_occ.perm];
  assign ok_vir = tri_vir.distinct && (tri_vir.s2 < n_vir) && op_set[tri_vir.perm];
  assign pin_occ_ok = {6'd0, packed_occ_in} < aps_pkg::CHOOSE3[n_occ];
  assign pin_vir_ok = {3'd0, packed_vir_in} < aps_pkg::CHOOSE3[n_vir];

  always_comb begin
    unique case (layout)
      aps_pkg::LAYOUT_VIR:  hit = pin_occ_ok && ok_vir;
      aps_pkg::LAYOUT_OCC:  hit = pin_vir_ok && ok_occ;
      aps_pkg::LAYOUT_FULL: hit = ok_occ && ok_vir;
      default:              hit = 1'b0;
    endcase
  end

  // Sign: odd permutations of the sides that are sorted
  assign neg = ((layout != aps_pkg::LAYOUT_VIR) && aps_pkg::PERM_ODD[tri_occ.perm]) ^
               ((layout != aps_pkg::LAYOUT_OCC) && aps_pkg::PERM_ODD[tri_vir.perm]);

  logic [5:0]         s1_o0, s1_o1, s1_o2, s1_v0, s1_v1, s1_v2;
  logic [9:0]         s1_pin_occ;
  logic [12:0]        s1_pin_vir;
  logic               s1_row_pin, s1_col_pin, s1_neg;
  logic signed [31:0] s1_re, s1_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid && s_tready && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_o0      <= tri_occ.s0;
      s1_o1      <= tri_occ.s1;
      s1_o2      <= tri_occ.s2;
      s1_v0      <= tri_vir.s0;
      s1_v1      <= tri_vir.s1;
      s1_v2      <= tri_vir.s2;
      s1_pin_occ <= packed_occ_in;
      s1_pin_vir <= packed_vir_in;
      s1_row_pin <= (layout == aps_pkg::LAYOUT_VIR);
      s1_col_pin <= (layout == aps_pkg::LAYOUT_OCC);
      s1_neg     <= neg;
      s1_re      <= elem_re;
      s1_im      <= elem_im;
    end
  end

  // Stage two: binomial table terms and the scale products
  logic [15:0]        s2_t1_occ, s2_t2_occ, s2_t1_vir, s2_t2_vir;
  logic [9:0]         s2_pin_occ;
  logic [12:0]        s2_pin_vir;
  logic               s2_row_pin, s2_col_pin, s2_neg;
  logic signed [63:0] s2_prod_re, s2_prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_t1_occ  <= aps_pkg::CHOOSE3[n_occ] - aps_pkg::CHOOSE3[6'(n_occ - s1_o0)];
      s2_t2_occ  <= aps_pkg::CHOOSE2[6'(n_occ - s1_o0 - 6'd1)]
                    - aps_pkg::CHOOSE2[6'(n_occ - s1_o1)]
                    + {10'd0, 6'(s1_o2 - s1_o1 - 6'd1)};
      s2_t1_vir  <= aps_pkg::CHOOSE3[n_vir] - aps_pkg::CHOOSE3[6'(n_vir - s1_v0)];
      s2_t2_vir  <= aps_pkg::CHOOSE2[6'(n_vir - s1_v0 - 6'd1)]
                    - aps_pkg::CHOOSE2[6'(n_vir - s1_v1)]
                    + {10'd0, 6'(s1_v2 - s1_v1 - 6'd1)};
      s2_pin_occ <= s1_pin_occ;
      s2_pin_vir <= s1_pin_vir;
      s2_row_pin <= s1_row_pin;
      s2_col_pin <= s1_col_pin;
      s2_neg     <= s1_neg;
      s2_prod_re <= scale * s1_re;
      s2_prod_im <= scale * s1_im;
    end
  end

  // Stage three: rank sums, sign and clamp into the output register
  logic [15:0]        rank_occ, rank_vir;
  logic signed [63:0] signed_re, signed_im;
  assign rank_occ  = s2_t1_occ + s2_t2_occ;
  assign rank_vir  = s2_t1_vir + s2_t2_vir;
  assign signed_re = s2_neg ? -s2_prod_re : s2_prod_re;
  assign signed_im = s2_neg ? -s2_prod_im : s2_prod_im;

  logic [9:0]  packed_row;
  logic [12:0] packed_col;
  logic [47:0] contrib_re, contrib_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      packed_row <= s2_row_pin ? s2_pin_occ : rank_occ[9:0];
      packed_col <= s2_col_pin ? s2_pin_vir : rank_vir[12:0];
      contrib_re <= aps_pkg::sat48(signed_re);
      contrib_im <= aps_pkg::sat48(signed_im);
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {1'b0, contrib_im, contrib_re, packed_col, packed_row};

endmodule

/* rtl/aps_checker.sv */
// Port-level checker for the antisymmetric packed scatter, bound to the top level.
module aps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [aps_pkg::OUT_W-1:0]       m_tdata
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // With the output empty the pipeline can always take an element
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // With no backpressure and no reset, each result traces back to an accepted input transaction
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) &&
    !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
    |-> $past(s_tvalid && s_tready, 3))
    else $error("result without a matching input transaction");

endmodule

bind antisymmetric_packed_scatter aps_checker u_aps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
